// File: rtl/btc_pkg.sv
// shared constants and types for the blank-to-tab compressor
package btc_pkg;

  // text codes
  localparam logic [7:0] ChBlank   = 8'd32;
  localparam logic [7:0] ChTab     = 8'd9;
  localparam logic [7:0] ChNewline = 8'd10;

  // widths
  localparam int unsigned ColW   = 8;
  localparam int unsigned CntW   = 6;
  localparam int unsigned StopsW = 64;
  localparam int unsigned AddrW  = 4;

  // line geometry and pending limit
  localparam logic [ColW-1:0] LineWidth  = 8'd128;
  localparam logic [ColW-1:0] ColLast    = LineWidth + 8'd1;
  localparam logic [ColW-1:0] ColFirst   = 8'd1;
  localparam logic [CntW-1:0] MaxPending = 6'd63;

  // bitmap reset: a stop every eight columns
  localparam logic [StopsW-1:0] StopsReset = 64'h8080_8080_8080_8080;

  // register select on paddr bit 3
  localparam logic RegStopsLow  = 1'b0;
  localparam logic RegStopsHigh = 1'b1;

  // bitmap write request from the register port
  typedef struct packed {
    logic              wr_low;
    logic              wr_high;
    logic [StopsW-1:0] data;
  } cfg_wr_t;

endpackage

// File: rtl/blank_to_tab_compressor.sv
// Blank-to-tab compressor top level: register port and block wiring.
// A blank is absorbed and emits nothing. Any other byte is taken in the idle state,
// then emits one word at a time (pending tabs, pending blanks unless the byte is a
// tab, the byte), holding while the output stalls. After a tab the column steps to
// the next stop, set by the single stop-lookup and incrementer.
// Reset is asynchronous active low: column 1, no pending counts, stops every 8.
module blank_to_tab_compressor
  import btc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output logic [7:0]        out_byte_o,
  output logic              last_o,
  input  logic              out_stall_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [StopsW-1:0] pwdata,
  output logic [StopsW-1:0] prdata,
  output logic              pready
);

  cfg_wr_t           cfg_wr;
  logic              wr_en;
  logic [ColW-1:0]   col;
  logic              stop;
  logic [StopsW-1:0] stops_low;
  logic [StopsW-1:0] stops_high;

  // register decode, registers 8 bytes apart
  assign pready         = 1'b1;
  assign wr_en          = psel && penable && pwrite && pready;
  assign cfg_wr.wr_low  = wr_en && (paddr[3] == RegStopsLow);
  assign cfg_wr.wr_high = wr_en && (paddr[3] == RegStopsHigh);
  assign cfg_wr.data    = pwdata;

  // read mux
  assign prdata = (paddr[3] == RegStopsHigh) ? stops_high : stops_low;

  btc_stops u_stops (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_i     (cfg_wr),
    .col_i        (col),
    .stop_o       (stop),
    .stops_low_o  (stops_low),
    .stops_high_o (stops_high)
  );

  btc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_byte_i   (in_byte_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .out_stall_i (out_stall_i),
    .col_o       (col),
    .stop_i      (stop)
  );

endmodule

// File: rtl/btc_stops.sv
// tab-stop bitmap registers and the stop lookup for one column
module btc_stops
  import btc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_wr_t           cfg_wr_i,
  input  logic [ColW-1:0]   col_i,
  output logic              stop_o,
  output logic [StopsW-1:0] stops_low_o,
  output logic [StopsW-1:0] stops_high_o
);

  logic [StopsW-1:0]   stops_low_q;
  logic [StopsW-1:0]   stops_high_q;
  logic [2*StopsW-1:0] bitmap;
  logic [ColW-1:0]     col_idx;

  // bitmap registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stops_low_q  <= StopsReset;
      stops_high_q <= StopsReset;
    end else begin
      if (cfg_wr_i.wr_low) begin
        stops_low_q <= cfg_wr_i.data;
      end
      if (cfg_wr_i.wr_high) begin
        stops_high_q <= cfg_wr_i.data;
      end
    end
  end

  // columns past the line width are always stops
  assign bitmap  = {stops_high_q, stops_low_q};
  assign col_idx = col_i - ColFirst;
  assign stop_o  = col_idx[ColW-1] ? 1'b1 : bitmap[col_idx[ColW-2:0]];

  assign stops_low_o  = stops_low_q;
  assign stops_high_o = stops_high_q;

endmodule

// File: rtl/btc_core.sv
// sequencer: pending counts, column tracking and one output word per cycle while not stalled
module btc_core
  import btc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            last_o,
  input  logic            out_stall_i,
  output logic [ColW-1:0] col_o,
  input  logic            stop_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StTabs  = 3'd1;
  localparam logic [2:0] StBlank = 3'd2;
  localparam logic [2:0] StByte  = 3'd3;
  localparam logic [2:0] StSeek  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [7:0]      byte_q, byte_d;
  logic [ColW-1:0] col_q, col_d;
  logic [CntW-1:0] blanks_q, blanks_d;
  logic [CntW-1:0] tabs_q, tabs_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            last_q, last_d;

  logic            out_free;
  logic            accept;
  logic [ColW-1:0] col_adv;
  logic [CntW:0]   pend_sum;
  logic            is_tab;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && (state_q == StIdle);
  assign col_adv  = (col_q >= ColLast) ? ColLast : col_q + 8'd1;
  assign pend_sum = {1'b0, blanks_q} + {1'b0, tabs_q};
  assign is_tab   = (byte_q == ChTab);

  // sequencer
  always_comb begin
    state_d     = state_q;
    byte_d      = byte_q;
    col_d       = col_q;
    blanks_d    = blanks_q;
    tabs_d      = tabs_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    last_d      = last_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          byte_d = in_byte_i;
          if (in_byte_i == ChBlank) begin
            // blank: hold back, turn into a pending tab, or drop at the pending limit
            col_d = col_adv;
            if (!stop_i) begin
              if (pend_sum < {1'b0, MaxPending}) begin
                blanks_d = blanks_q + 6'd1;
              end
            end else if (blanks_q != '0 || tabs_q < MaxPending) begin
              blanks_d = '0;
              tabs_d   = tabs_q + 6'd1;
            end
          end else if (tabs_q != '0) begin
            state_d = StTabs;
          end else if (in_byte_i != ChTab && blanks_q != '0) begin
            state_d = StBlank;
          end else begin
            state_d = StByte;
          end
        end
      end
      StTabs: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = ChTab;
          last_d      = 1'b0;
          tabs_d      = tabs_q - 6'd1;
          if (tabs_q == 6'd1) begin
            state_d = (!is_tab && blanks_q != '0) ? StBlank : StByte;
          end
        end
      end
      StBlank: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = ChBlank;
          last_d      = 1'b0;
          blanks_d    = blanks_q - 6'd1;
          if (blanks_q == 6'd1) begin
            state_d = StByte;
          end
        end
      end
      StByte: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = byte_q;
          last_d      = 1'b1;
          blanks_d    = '0;
          tabs_d      = '0;
          if (byte_q == ChNewline) begin
            col_d   = ColFirst;
            state_d = StIdle;
          end else if (is_tab) begin
            state_d = StSeek;
          end else begin
            col_d   = col_adv;
            state_d = StIdle;
          end
        end
      end
      StSeek: begin
        // step one column per cycle until a stop, then move past it
        col_d = col_adv;
        if (stop_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      col_q       <= ColFirst;
      blanks_q    <= '0;
      tabs_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      blanks_q    <= blanks_d;
      tabs_q      <= tabs_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;
  assign col_o       = col_q;

endmodule

// File: tb/btc_checker.sv
// checker for the blank-to-tab compressor: watches both channels, predicts and compares words
module btc_checker
  import btc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_stall_i,
  input  logic              out_valid_i,
  input  logic [7:0]        out_byte_i,
  input  logic              last_i,
  input  logic              out_stall_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [AddrW-1:0]  paddr_i,
  input  logic [StopsW-1:0] pwdata_i,
  input  logic              pready_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_word_t;

  // shadow of the stop bitmap and the line state
  logic [StopsW-1:0] stops_lo;
  logic [StopsW-1:0] stops_hi;
  logic [ColW-1:0]   cur_col;
  logic [CntW-1:0]   held_blanks;
  logic [CntW-1:0]   held_tabs;

  out_word_t expected_words[$];
  out_word_t want;
  int        fails = 0;

  // columns past the line width are always stops
  function automatic logic col_is_stop(logic [ColW-1:0] col);
    logic [ColW-1:0] bit_idx;
    if (col > LineWidth) return 1'b1;
    if (col == '0) return 1'b0;
    bit_idx = (col <= 8'd64) ? col - 8'd1 : col - 8'd65;
    return (col <= 8'd64) ? stops_lo[bit_idx[5:0]] : stops_hi[bit_idx[5:0]];
  endfunction

  function automatic logic [ColW-1:0] step_col(logic [ColW-1:0] col);
    return (col >= ColLast) ? ColLast : col + 8'd1;
  endfunction

  function automatic void push_word(logic [7:0] ch, logic last);
    out_word_t w;
    w.ch   = ch;
    w.last = last;
    expected_words.push_back(w);
  endfunction

  // update the line state for one text byte and queue the words it emits
  function automatic void predict_words(logic [7:0] ch);
    int n;
    n = 0;
    if (cur_col < ColFirst || cur_col > ColLast) cur_col = ColLast;
    if (ch == ChBlank) begin
      if (!col_is_stop(cur_col)) begin
        if (int'(held_blanks) + int'(held_tabs) < int'(MaxPending)) held_blanks++;
      end else if (held_blanks != '0 || held_tabs < MaxPending) begin
        held_blanks = '0;
        held_tabs++;
      end
      cur_col = step_col(cur_col);
      return;
    end
    // pending tabs go first
    while (held_tabs != '0 && n < int'(MaxPending)) begin
      push_word(ChTab, 1'b0);
      n++;
      held_tabs--;
    end
    held_tabs = '0;
    // a tab swallows the pending blanks
    if (ch != ChTab) begin
      while (held_blanks != '0 && n < int'(MaxPending)) begin
        push_word(ChBlank, 1'b0);
        n++;
        held_blanks--;
      end
    end
    held_blanks = '0;
    push_word(ch, 1'b1);
    if (ch == ChNewline) begin
      cur_col = ColFirst;
    end else begin
      if (ch == ChTab) begin
        while (!col_is_stop(cur_col)) cur_col = step_col(cur_col);
      end
      cur_col = step_col(cur_col);
    end
  endfunction

  // register writes, then accepted input bytes, then accepted output words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stops_lo    = StopsReset;
      stops_hi    = StopsReset;
      cur_col     = ColFirst;
      held_blanks = '0;
      held_tabs   = '0;
      expected_words.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[2:0] == 3'b000) begin
        if (paddr_i[3] == RegStopsLow) stops_lo = pwdata_i;
        else stops_hi = pwdata_i;
      end
      if (in_valid_i && !in_stall_i) predict_words(in_byte_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, got out_byte %0d last %0d",
                   $time, out_byte_i, last_i);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (want.ch != out_byte_i) begin
            $display("%0t: out_byte expected %0d, got %0d", $time, want.ch, out_byte_i);
            fails++;
          end
          if (want.last != last_i) begin
            $display("%0t: last expected %0d, got %0d", $time, want.last, last_i);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_words.size();
  end

endmodule

// File: tb/blank_to_tab_compressor_tb.sv
// testbench top for the blank-to-tab compressor: stimulus, register writes and verdict
module blank_to_tab_compressor_tb
  import btc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SettleCycles  = 200;
  localparam int WatchdogLimit = 2000;

  localparam logic [AddrW-1:0] AddrStopsLow  = {RegStopsLow, 3'b000};
  localparam logic [AddrW-1:0] AddrStopsHigh = {RegStopsHigh, 3'b000};

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic [7:0]        in_byte_i   = '0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [7:0]        out_byte_o;
  logic              last_o;
  logic              out_stall_i = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [AddrW-1:0]  paddr       = '0;
  logic [StopsW-1:0] pwdata      = '0;
  logic [StopsW-1:0] prdata;
  logic              pready;

  int   fail_count;
  int   pending_words;
  int   idle_cycles = 0;
  logic no_idle     = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  blank_to_tab_compressor u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_byte_i   (in_byte_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .out_stall_i (out_stall_i),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  btc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_byte_i    (in_byte_i),
    .in_stall_i   (in_stall_o),
    .out_valid_i  (out_valid_o),
    .out_byte_i   (out_byte_o),
    .last_i       (last_o),
    .out_stall_i  (out_stall_i),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  // watchdog on cycles where neither channel moves a word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL blank_to_tab_compressor");
        $finish;
      end
    end
  end

  // receiver: random stall before each output word
  initial begin
    int hold;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // one input word with a random gap in front
  task automatic send_char(input logic [7:0] ch);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= ch;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // register write: setup phase, access phase until pready, then the bus is left idle
  task automatic write_stops(input logic [AddrW-1:0] addr, input logic [StopsW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // let every expected word out, then give a tab walk time to finish
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // random text: blank runs, words, tabs, newlines and raw bytes
  task automatic send_text(input int budget, input int lead_blanks);
    int sent;
    int pick;
    int len;
    sent = 0;
    if (lead_blanks > 0) begin
      repeat (lead_blanks) send_char(ChBlank);
      send_char(8'h78);
      sent = lead_blanks + 1;
    end
    while (sent < budget) begin
      if ($urandom_range(0, 5) == 0) no_idle = !no_idle;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 12);
        repeat (len) send_char(ChBlank);
        sent += len;
      end else if (pick < 65) begin
        len = $urandom_range(1, 8);
        repeat (len) send_char(8'($urandom_range(33, 126)));
        sent += len;
      end else if (pick < 75) begin
        send_char(ChTab);
        sent++;
      end else if (pick < 82) begin
        send_char(ChNewline);
        sent++;
      end else begin
        send_char(8'($urandom_range(0, 255)));
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    logic [7:0] opening [19];
    opening = '{8'h41, ChBlank, ChBlank, ChBlank, ChBlank, ChBlank, ChBlank, ChBlank,
                8'h00, ChTab, ChBlank, ChBlank, ChTab, ChBlank, 8'hFF, ChNewline,
                ChBlank, ChNewline, ChTab};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed text on the reset stops
    foreach (opening[i]) send_char(opening[i]);
    settle();

    // no stops inside the line: blank count overflows
    write_stops(AddrStopsLow, '0);
    write_stops(AddrStopsHigh, '0);
    send_text(75, 75);
    settle();

    // every column a stop: tab count overflows
    write_stops(AddrStopsLow, '1);
    write_stops(AddrStopsHigh, '1);
    send_text(75, 70);
    settle();

    // random bitmap
    write_stops(AddrStopsLow, {$urandom, $urandom});
    write_stops(AddrStopsHigh, {$urandom, $urandom});
    send_text(70, 0);
    settle();

    // sparse low half, full high half
    write_stops(AddrStopsLow, {$urandom, $urandom} & {$urandom, $urandom});
    write_stops(AddrStopsHigh, '1);
    send_text(60, 0);
    settle();

    // back to a stop every eight columns
    write_stops(AddrStopsLow, StopsReset);
    write_stops(AddrStopsHigh, StopsReset);
    send_text(80, 0);
    settle();

    if (fail_count == 0 && pending_words == 0) begin
      $display("PASS blank_to_tab_compressor");
    end else begin
      $display("FAIL blank_to_tab_compressor");
    end
    $finish;
  end

endmodule
